FILE: src/qmm_pkg.sv
// Shared types, constants and helper functions of the quad motor mixer.
package qmm_pkg;

  // Pipeline depths
  localparam int MIX_LAT     = 2;
  localparam int SQRT_STAGES = 16;
  localparam int DIV_BITS    = 15;
  localparam int DUTY_LAT    = DIV_BITS + 6;
  localparam int TOTAL_LAT   = MIX_LAT + SQRT_STAGES + DUTY_LAT;
  localparam int FLAG_DLY    = SQRT_STAGES + DUTY_LAT;

  localparam int ADDR_W = 5;

  // Largest squared speed kept, Q32.16
  localparam logic [47:0] SQ_LIMIT = 48'hFFFF_FFFF_FFFF;

  // x/100 as (x*RECIP) >> RECIP_SHIFT, exact for x < 2^23
  localparam logic [23:0] RECIP       = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  typedef enum logic [2:0] {
    REG_THRUST_GAIN     = 3'd0,
    REG_ROLL_PITCH_GAIN = 3'd1,
    REG_YAW_GAIN        = 3'd2,
    REG_DUTY_LO         = 3'd3,
    REG_DUTY_HI         = 3'd4,
    REG_SPEED_LO        = 3'd5,
    REG_SPEED_HI        = 3'd6,
    REG_PERIOD          = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    DUTY_MIN = 3'b001,
    DUTY_MAX = 3'b010,
    DUTY_DIV = 3'b100
  } duty_sel_e;

  typedef struct packed {
    logic [31:0] thrust_gain;
    logic [31:0] roll_pitch_gain;
    logic [31:0] yaw_gain;
    logic [14:0] duty_lo;
    logic [14:0] duty_hi;
    logic [31:0] speed_lo;
    logic [31:0] speed_hi;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_state_t;

  // One digit of the bitwise integer square root
  function automatic sq_state_t sqrt_step(sq_state_t s);
    sq_state_t   res;
    logic [35:0] r2;
    logic [35:0] trial;
    r2    = {s.rem[33:0], s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    if (r2 >= trial) begin
      res.rem  = r2 - trial;
      res.root = {s.root[30:0], 1'b1};
    end else begin
      res.rem  = r2;
      res.root = {s.root[30:0], 1'b0};
    end
    res.rad = {s.rad[61:0], 2'b00};
    return res;
  endfunction

endpackage

FILE: src/qmm_if.sv
// Command and result channel interfaces of the quad motor mixer.
interface qmm_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] thrust;
  logic signed [31:0] roll_torque;
  logic signed [31:0] pitch_torque;
  logic signed [31:0] yaw_torque;

  modport source (output valid, thrust, roll_torque, pitch_torque, yaw_torque, input ready);
  modport sink   (input valid, thrust, roll_torque, pitch_torque, yaw_torque, output ready);
endinterface

interface qmm_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] compare_motor0;
  logic [15:0] compare_motor1;
  logic [15:0] compare_motor2;
  logic [15:0] compare_motor3;
  logic [3:0]  negative_flags;

  modport source (output valid, compare_motor0, compare_motor1, compare_motor2,
                  compare_motor3, negative_flags, input ready);
  modport sink   (input valid, compare_motor0, compare_motor1, compare_motor2,
                  compare_motor3, negative_flags, output ready);
endinterface

FILE: src/qmm_regs.sv
// APB configuration registers of the quad motor mixer.
module qmm_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [qmm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output qmm_pkg::cfg_t             cfg_o
);

  qmm_pkg::cfg_t     cfg_q;
  qmm_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = qmm_pkg::reg_idx_e'(paddr[qmm_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thrust_gain     <= 32'd65536;
      cfg_q.roll_pitch_gain <= 32'd65536;
      cfg_q.yaw_gain        <= 32'd65536;
      cfg_q.duty_lo         <= 15'd1280;
      cfg_q.duty_hi         <= 15'd2560;
      cfg_q.speed_lo        <= 32'd0;
      cfg_q.speed_hi        <= 32'd65536000;
      cfg_q.period          <= 16'd65535;
    end else if (wr_en) begin
      unique case (idx)
        qmm_pkg::REG_THRUST_GAIN:     cfg_q.thrust_gain     <= pwdata;
        qmm_pkg::REG_ROLL_PITCH_GAIN: cfg_q.roll_pitch_gain <= pwdata;
        qmm_pkg::REG_YAW_GAIN:        cfg_q.yaw_gain        <= pwdata;
        qmm_pkg::REG_DUTY_LO:         cfg_q.duty_lo         <= pwdata[14:0];
        qmm_pkg::REG_DUTY_HI:         cfg_q.duty_hi         <= pwdata[14:0];
        qmm_pkg::REG_SPEED_LO:        cfg_q.speed_lo        <= pwdata;
        qmm_pkg::REG_SPEED_HI:        cfg_q.speed_hi        <= pwdata;
        qmm_pkg::REG_PERIOD:          cfg_q.period          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      qmm_pkg::REG_THRUST_GAIN:     prdata = cfg_q.thrust_gain;
      qmm_pkg::REG_ROLL_PITCH_GAIN: prdata = cfg_q.roll_pitch_gain;
      qmm_pkg::REG_YAW_GAIN:        prdata = cfg_q.yaw_gain;
      qmm_pkg::REG_DUTY_LO:         prdata = {17'd0, cfg_q.duty_lo};
      qmm_pkg::REG_DUTY_HI:         prdata = {17'd0, cfg_q.duty_hi};
      qmm_pkg::REG_SPEED_LO:        prdata = cfg_q.speed_lo;
      qmm_pkg::REG_SPEED_HI:        prdata = cfg_q.speed_hi;
      qmm_pkg::REG_PERIOD:          prdata = {16'd0, cfg_q.period};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/qmm_mix.sv
// Mixer: gain products, then X-pattern sums with clamp to [0, 2^48-1].
module qmm_mix (
  input  logic               clk_i,
  input  logic               en_i,
  input  qmm_pkg::cfg_t      cfg_i,
  input  logic signed [31:0] thrust_i,
  input  logic signed [31:0] roll_i,
  input  logic signed [31:0] pitch_i,
  input  logic signed [31:0] yaw_i,
  output logic [3:0][47:0]   sq_o,
  output logic [3:0]         neg_o
);

  logic signed [65:0] t_p, r_p, p_p, y_p;
  logic signed [47:0] t_q, r_q, p_q, y_q;
  logic signed [49:0] s [4];
  logic [3:0][47:0]   sq_d, sq_q;
  logic [3:0]         neg_d, neg_q;

  // stage 1: gain products, floored to Q32.16
  assign t_p = $signed({1'b0, cfg_i.thrust_gain})     * $signed({thrust_i[31], thrust_i});
  assign r_p = $signed({1'b0, cfg_i.roll_pitch_gain}) * $signed({roll_i[31], roll_i});
  assign p_p = $signed({1'b0, cfg_i.roll_pitch_gain}) * $signed({pitch_i[31], pitch_i});
  assign y_p = $signed({1'b0, cfg_i.yaw_gain})        * $signed({yaw_i[31], yaw_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_p[63:16];
      r_q <= r_p[63:16];
      p_q <= p_p[63:16];
      y_q <= y_p[63:16];
    end
  end

  // stage 2: motor sums and clamp
  always_comb begin
    s[0] = 50'(t_q) + 50'(p_q) - 50'(y_q);
    s[1] = 50'(t_q) - 50'(r_q) + 50'(y_q);
    s[2] = 50'(t_q) - 50'(p_q) - 50'(y_q);
    s[3] = 50'(t_q) + 50'(r_q) + 50'(y_q);
    for (int i = 0; i < 4; i++) begin
      neg_d[i] = s[i][49];
      if (s[i][49]) begin
        sq_d[i] = 48'd0;
      end else if (s[i][48]) begin
        sq_d[i] = qmm_pkg::SQ_LIMIT;
      end else begin
        sq_d[i] = s[i][47:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      neg_q <= neg_d;
    end
  end

  assign sq_o  = sq_q;
  assign neg_o = neg_q;

endmodule

FILE: src/qmm_sqrt.sv
// Pipelined integer square root of a Q32.16 value into a Q16.16 root, two digits per stage.
module qmm_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [47:0] sq_i,
  output logic [31:0] root_o
);

  qmm_pkg::sq_state_t st_q [qmm_pkg::SQRT_STAGES];

  for (genvar k = 0; k < qmm_pkg::SQRT_STAGES; k++) begin : g_stage
    qmm_pkg::sq_state_t st_in;
    qmm_pkg::sq_state_t st_d;

    if (k == 0) begin : g_first
      assign st_in = '{rem: 36'd0, root: 32'd0, rad: {sq_i, 16'd0}};
    end else begin : g_next
      assign st_in = st_q[k-1];
    end

    assign st_d = qmm_pkg::sqrt_step(qmm_pkg::sqrt_step(st_in));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign root_o = st_q[qmm_pkg::SQRT_STAGES-1].root;

endmodule

FILE: src/qmm_duty.sv
// Speed to duty mapping with clamp, pipelined divider, and compare scaling.
module qmm_duty (
  input  logic          clk_i,
  input  logic          en_i,
  input  qmm_pkg::cfg_t cfg_i,
  input  logic [31:0]   speed_i,
  output logic [15:0]   cmp_o
);

  localparam int NB = qmm_pkg::DIV_BITS;
  localparam int NW = 32 + NB;

  qmm_pkg::duty_sel_e sel_d, sel_q, sel1_q;
  logic [31:0]        s_q, den_q, den1_q;
  logic [NB-1:0]      dr_q;
  logic [NW-1:0]      n_q;

  qmm_pkg::duty_sel_e dsel_q [NB];
  logic [31:0]        dden_q [NB];
  logic [NW-1:0]      rem_q  [NB];
  logic [NB-1:0]      quo_q  [NB];

  logic [NB-1:0]      duty_d, duty_q;
  logic [30:0]        prod_q;
  logic [46:0]        rec_q;
  logic [16:0]        c100;
  logic [15:0]        cmp_q;

  // stage: classify and form differences
  // inverted duty range: the double clamp yields the high duty above the low
  // speed and the low duty at or below it; a flat speed range yields the
  // high duty there
  always_comb begin
    if (cfg_i.speed_hi <= cfg_i.speed_lo) begin
      sel_d = (cfg_i.duty_lo > cfg_i.duty_hi) ? qmm_pkg::DUTY_MAX : qmm_pkg::DUTY_MIN;
    end else if (speed_i <= cfg_i.speed_lo) begin
      sel_d = qmm_pkg::DUTY_MIN;
    end else if (cfg_i.duty_lo > cfg_i.duty_hi) begin
      sel_d = qmm_pkg::DUTY_MAX;
    end else if (speed_i >= cfg_i.speed_hi) begin
      sel_d = qmm_pkg::DUTY_MAX;
    end else begin
      sel_d = qmm_pkg::DUTY_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q <= sel_d;
      s_q   <= speed_i - cfg_i.speed_lo;
      den_q <= cfg_i.speed_hi - cfg_i.speed_lo;
      dr_q  <= cfg_i.duty_hi - cfg_i.duty_lo;
    end
  end

  // stage: numerator product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= dr_q * s_q;
      sel1_q <= sel_q;
      den1_q <= den_q;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < NB; j++) begin : g_div
    localparam int BIT = NB - 1 - j;
    logic [NW-1:0] rem_in, dsh, rem_d;
    logic [NB-1:0] quo_in, quo_d;
    logic [31:0]   den_in;
    qmm_pkg::duty_sel_e sel_in;

    if (j == 0) begin : g_first
      assign rem_in = n_q;
      assign quo_in = '0;
      assign den_in = den1_q;
      assign sel_in = sel1_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = dden_q[j-1];
      assign sel_in = dsel_q[j-1];
    end

    assign dsh = NW'(den_in) << BIT;

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= dsh) begin
        rem_d      = rem_in - dsh;
        quo_d[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        dden_q[j] <= den_in;
        dsel_q[j] <= sel_in;
      end
    end
  end

  // stage: final duty
  always_comb begin
    unique case (dsel_q[NB-1])
      qmm_pkg::DUTY_MIN: duty_d = cfg_i.duty_lo;
      qmm_pkg::DUTY_MAX: duty_d = cfg_i.duty_hi;
      qmm_pkg::DUTY_DIV: duty_d = cfg_i.duty_lo + quo_q[NB-1];
      default:           duty_d = cfg_i.duty_lo;
    endcase
  end

  assign c100 = rec_q[46:qmm_pkg::RECIP_SHIFT];

  // stages: period*duty, divide by 256 then by 100, saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      duty_q <= duty_d;
      prod_q <= cfg_i.period * duty_q;
      rec_q  <= prod_q[30:8] * qmm_pkg::RECIP;
      cmp_q  <= c100[16] ? 16'hFFFF : c100[15:0];
    end
  end

  assign cmp_o = cmp_q;

endmodule

FILE: src/quad_motor_mixer_to_pwm_core.sv
// A command request passes the registered mix, root and duty/compare stages to the result.
// Throughput: one command request per cycle while the pipeline advances; every stage is registered.
// The pipeline advances whenever the output register is empty or taken.
// Reset (rst_ni low, async) clears all valid bits and loads register defaults.
// Data registers are not reset; configuration is to be changed only while idle (not enforced here).
module quad_motor_mixer_to_pwm_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  qmm_cmd_if.sink                    cmd_i,
  qmm_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qmm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int LAT = qmm_pkg::TOTAL_LAT;

  qmm_pkg::cfg_t    cfg;
  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [3:0][47:0] sq;
  logic [3:0]       neg;
  logic [31:0]      root [4];
  logic [15:0]      cmp  [4];
  logic [3:0]       flag_q [qmm_pkg::FLAG_DLY];

  // whole pipeline moves unless the output holds an unread result
  assign en          = ~vld_q[LAT-1] | res_o.ready;
  assign cmd_i.ready = en;

  qmm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qmm_mix u_mix (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .thrust_i (cmd_i.thrust),
    .roll_i   (cmd_i.roll_torque),
    .pitch_i  (cmd_i.pitch_torque),
    .yaw_i    (cmd_i.yaw_torque),
    .sq_o     (sq),
    .neg_o    (neg)
  );

  for (genvar m = 0; m < 4; m++) begin : g_motor
    qmm_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .sq_i   (sq[m]),
      .root_o (root[m])
    );

    qmm_duty u_duty (
      .clk_i   (clk_i),
      .en_i    (en),
      .cfg_i   (cfg),
      .speed_i (root[m]),
      .cmp_o   (cmp[m])
    );
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], cmd_i.valid};
    end
  end

  // negative flags delayed to line up with the compare values
  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_q[0] <= neg;
      for (int i = 1; i < qmm_pkg::FLAG_DLY; i++) begin
        flag_q[i] <= flag_q[i-1];
      end
    end
  end

  assign res_o.valid          = vld_q[LAT-1];
  assign res_o.compare_motor0 = cmp[0];
  assign res_o.compare_motor1 = cmp[1];
  assign res_o.compare_motor2 = cmp[2];
  assign res_o.compare_motor3 = cmp[3];
  assign res_o.negative_flags = flag_q[qmm_pkg::FLAG_DLY-1];

endmodule

FILE: verif/qmm_compare_checker.sv
// Checker for the quad motor mixer: mirrors the registers, predicts compare values and flags.
module qmm_compare_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  qmm_cmd_if                         cmd,
  qmm_res_if                         res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qmm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         errors_o,
  output int                         pending_o,
  output int                         results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] cmp0;
    logic [15:0] cmp1;
    logic [15:0] cmp2;
    logic [15:0] cmp3;
    logic [3:0]  neg;
  } motor_out_t;

  qmm_pkg::cfg_t cfg_copy;
  motor_out_t    exp_compares[$];

  // floor division for a positive divisor
  function automatic longint floor_div(longint a, longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  // bitwise integer square root of a 64-bit value
  function automatic logic [31:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic longint duty_clamp(longint d, qmm_pkg::cfg_t c);
    if (d < longint'(c.duty_lo)) return longint'(c.duty_lo);
    if (d > longint'(c.duty_hi)) return longint'(c.duty_hi);
    return d;
  endfunction

  // speed (Q16.16) to timer compare value
  function automatic logic [15:0] speed_compare(logic [31:0] spd, qmm_pkg::cfg_t c);
    longint duty;
    longint num;
    longint den;
    longint cmp;
    if (c.speed_hi <= c.speed_lo) begin
      duty = longint'(c.duty_lo);
    end else begin
      num  = (longint'(c.duty_hi) - longint'(c.duty_lo)) *
             (longint'(spd) - longint'(c.speed_lo));
      den  = longint'(c.speed_hi) - longint'(c.speed_lo);
      duty = duty_clamp(longint'(c.duty_lo) + floor_div(num, den), c);
    end
    duty = duty_clamp(duty, c);
    cmp  = longint'(c.period) * duty / 25600;
    if (cmp > 65535) cmp = 65535;
    return cmp[15:0];
  endfunction

  function automatic longint gain_mul(logic [31:0] g, logic signed [31:0] x);
    longint p;
    p = longint'(g) * longint'(x);
    return p >>> 16;
  endfunction

  // mix, clamp, root and map one command set
  function automatic motor_out_t predict_compares(logic signed [31:0] th, logic signed [31:0] ro,
                                                  logic signed [31:0] pi, logic signed [31:0] ya,
                                                  qmm_pkg::cfg_t c);
    motor_out_t  o;
    longint      t, r, p, y;
    longint      sq[4];
    logic [63:0] v;
    logic [15:0] cv[4];
    t = gain_mul(c.thrust_gain, th);
    r = gain_mul(c.roll_pitch_gain, ro);
    p = gain_mul(c.roll_pitch_gain, pi);
    y = gain_mul(c.yaw_gain, ya);
    sq[0] = t + p - y;
    sq[1] = t - r + y;
    sq[2] = t - p - y;
    sq[3] = t + r + y;
    o.neg = '0;
    for (int i = 0; i < 4; i++) begin
      if (sq[i] < 0) begin
        v = '0;
        o.neg[i] = 1'b1;
      end else begin
        v = sq[i];
        if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
      end
      cv[i] = speed_compare(root64(v << 16), c);
    end
    o.cmp0 = cv[0];
    o.cmp1 = cv[1];
    o.cmp2 = cv[2];
    o.cmp3 = cv[3];
    return o;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endtask

  initial begin
    errors_o  = 0;
    results_o = 0;
    pending_o = 0;
  end

  // register mirror, command predictions and result compare
  always @(posedge clk_i or negedge rst_ni) begin
    motor_out_t e;
    if (!rst_ni) begin
      cfg_copy.thrust_gain     <= 32'd65536;
      cfg_copy.roll_pitch_gain <= 32'd65536;
      cfg_copy.yaw_gain        <= 32'd65536;
      cfg_copy.duty_lo         <= 15'd1280;
      cfg_copy.duty_hi         <= 15'd2560;
      cfg_copy.speed_lo        <= 32'd0;
      cfg_copy.speed_hi        <= 32'd65536000;
      cfg_copy.period          <= 16'd65535;
      exp_compares.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (qmm_pkg::reg_idx_e'(paddr[4:2]))
          qmm_pkg::REG_THRUST_GAIN:     cfg_copy.thrust_gain     <= pwdata;
          qmm_pkg::REG_ROLL_PITCH_GAIN: cfg_copy.roll_pitch_gain <= pwdata;
          qmm_pkg::REG_YAW_GAIN:        cfg_copy.yaw_gain        <= pwdata;
          qmm_pkg::REG_DUTY_LO:         cfg_copy.duty_lo         <= pwdata[14:0];
          qmm_pkg::REG_DUTY_HI:         cfg_copy.duty_hi         <= pwdata[14:0];
          qmm_pkg::REG_SPEED_LO:        cfg_copy.speed_lo        <= pwdata;
          qmm_pkg::REG_SPEED_HI:        cfg_copy.speed_hi        <= pwdata;
          qmm_pkg::REG_PERIOD:          cfg_copy.period          <= pwdata[15:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        exp_compares.push_back(predict_compares(cmd.thrust, cmd.roll_torque,
                                                cmd.pitch_torque, cmd.yaw_torque, cfg_copy));
      if (res.valid && res.ready) begin
        results_o++;
        if (exp_compares.size() == 0) begin
          $error("result with no request outstanding");
          errors_o++;
        end else begin
          e = exp_compares.pop_front();
          check_field("compare_motor0", e.cmp0, res.compare_motor0);
          check_field("compare_motor1", e.cmp1, res.compare_motor1);
          check_field("compare_motor2", e.cmp2, res.compare_motor2);
          check_field("compare_motor3", e.cmp3, res.compare_motor3);
          check_field("negative_flags", 16'(e.neg), 16'(res.negative_flags));
        end
      end
    end
    pending_o = exp_compares.size();
  end

endmodule

FILE: verif/tb.sv
// Top of the quad motor mixer testbench: clock, reset, register writes and command traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 190;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [qmm_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  int                         errors;
  int                         pending;
  int                         results;
  int                         sent = 0;
  logic                       hold_req = 1'b0;

  qmm_cmd_if cmd();
  qmm_res_if res();

  initial begin
    cmd.valid        = 1'b0;
    cmd.thrust       = '0;
    cmd.roll_torque  = '0;
    cmd.pitch_torque = '0;
    cmd.yaw_torque   = '0;
    res.ready        = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  quad_motor_mixer_to_pwm_core dut (
    .clk_i, .rst_ni, .cmd_i(cmd), .res_o(res),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  qmm_compare_checker u_checker (
    .clk_i, .rst_ni, .cmd(cmd), .res(res),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic reg_write(qmm_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= qmm_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one command request, held until taken
  task automatic send_cmd(logic [31:0] th, logic [31:0] ro, logic [31:0] pi, logic [31:0] ya);
    int g;
    cmd.valid        <= 1'b1;
    cmd.thrust       <= th;
    cmd.roll_torque  <= ro;
    cmd.pitch_torque <= pi;
    cmd.yaw_torque   <= ya;
    do @(posedge clk_i); while (!cmd.ready);
    sent++;
    g = gap_len();
    if (g > 0) begin
      cmd.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // flight-like commands most of the time, raw bits otherwise
  task automatic send_random();
    logic [31:0] th, ro, pi, ya;
    if ($urandom_range(0, 99) < 70) begin
      th = $urandom_range(0, 32'h0400_0000);
      ro = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      pi = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
      ya = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    end else begin
      th = $urandom();
      ro = $urandom();
      pi = $urandom();
      ya = $urandom();
    end
    send_cmd(th, ro, pi, ya);
  endtask

  // let the pipeline drain fully before touching registers
  task automatic drain();
    cmd.valid <= 1'b0;
    wait (pending == 0);
    repeat (qmm_pkg::TOTAL_LAT + 5) @(posedge clk_i);
  endtask

  task automatic load_phase(int ph);
    logic [31:0] a, b;
    case (ph)
      1: begin
        reg_write(qmm_pkg::REG_THRUST_GAIN, $urandom_range(32'h4000, 32'h4_0000));
        reg_write(qmm_pkg::REG_ROLL_PITCH_GAIN, $urandom_range(32'h4000, 32'h4_0000));
        reg_write(qmm_pkg::REG_YAW_GAIN, $urandom_range(32'h4000, 32'h4_0000));
        reg_write(qmm_pkg::REG_DUTY_LO, 0);
        reg_write(qmm_pkg::REG_DUTY_HI, 25600);
        reg_write(qmm_pkg::REG_SPEED_LO, 0);
        reg_write(qmm_pkg::REG_SPEED_HI, 32'h0100_0000);
        reg_write(qmm_pkg::REG_PERIOD, 65535);
      end
      2: begin
        reg_write(qmm_pkg::REG_THRUST_GAIN, 32'hFFFF_FFFF);
        reg_write(qmm_pkg::REG_ROLL_PITCH_GAIN, 32'hFFFF_FFFF);
        reg_write(qmm_pkg::REG_YAW_GAIN, 32'hFFFF_FFFF);
        reg_write(qmm_pkg::REG_SPEED_LO, 32'h0123_4567);
        reg_write(qmm_pkg::REG_SPEED_HI, 32'h0123_4567);
        reg_write(qmm_pkg::REG_PERIOD, 1);
      end
      3: begin
        // inverted duty range
        reg_write(qmm_pkg::REG_THRUST_GAIN, 32'h1_0000);
        reg_write(qmm_pkg::REG_ROLL_PITCH_GAIN, 32'h1_0000);
        reg_write(qmm_pkg::REG_YAW_GAIN, 32'h1_0000);
        reg_write(qmm_pkg::REG_DUTY_LO, 20000);
        reg_write(qmm_pkg::REG_DUTY_HI, 5000);
        reg_write(qmm_pkg::REG_SPEED_LO, 0);
        reg_write(qmm_pkg::REG_SPEED_HI, 32'h0080_0000);
        reg_write(qmm_pkg::REG_PERIOD, $urandom_range(1, 65535));
      end
      4: begin
        reg_write(qmm_pkg::REG_THRUST_GAIN, 0);
        reg_write(qmm_pkg::REG_ROLL_PITCH_GAIN, 0);
        reg_write(qmm_pkg::REG_YAW_GAIN, 0);
        reg_write(qmm_pkg::REG_DUTY_LO, 25600);
        reg_write(qmm_pkg::REG_DUTY_HI, 25600);
        reg_write(qmm_pkg::REG_SPEED_LO, 32'hFFFF_FFFF);
        reg_write(qmm_pkg::REG_SPEED_HI, 0);
      end
      default: begin
        a = $urandom();
        b = $urandom();
        reg_write(qmm_pkg::REG_THRUST_GAIN, $urandom_range(0, 32'h8_0000));
        reg_write(qmm_pkg::REG_ROLL_PITCH_GAIN, $urandom_range(0, 32'h8_0000));
        reg_write(qmm_pkg::REG_YAW_GAIN, $urandom_range(0, 32'h8_0000));
        reg_write(qmm_pkg::REG_DUTY_LO, $urandom_range(0, 25600));
        reg_write(qmm_pkg::REG_DUTY_HI, $urandom_range(0, 25600));
        reg_write(qmm_pkg::REG_SPEED_LO, (a < b ? a : b) >> 6);
        reg_write(qmm_pkg::REG_SPEED_HI, (a < b ? b : a) >> 6);
        reg_write(qmm_pkg::REG_PERIOD, $urandom_range(1, 65535));
      end
    endcase
  endtask

  // result side: random back-pressure, one long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res.ready <= 1'b0;
        for (int n = 0; n < 300; n++) @(posedge clk_i);
        hold_req = 1'b0;
        res.ready <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0 || $urandom_range(0, 3) == 0) begin
          res.ready <= 1'b1;
        end else begin
          res.ready <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("FAIL quad_motor_mixer_to_pwm_core");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and several sign patterns at reset gains
    send_cmd(0, 0, 0, 0);
    send_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cmd(32'h7FFF_FFFF, 0, 0, 0);
    send_cmd(32'h8000_0000, 0, 0, 0);
    send_cmd(32'hFFFF_FFFF, 0, 0, 0);
    send_cmd(32'h0001_0000, 32'h0001_0000, 0, 0);
    send_cmd(32'h0001_0000, 0, 32'h0001_0000, 0);
    send_cmd(32'h0001_0000, 0, 0, 32'h0001_0000);
    send_cmd(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    send_cmd(0, 32'h7FFF_FFFF, 0, 0);
    send_cmd(0, 0, 32'h8000_0000, 0);
    send_cmd(0, 0, 0, 32'h7FFF_FFFF);
    send_cmd(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cmd(32'h03E8_0000, 0, 0, 0);
    send_cmd(32'h000F_4240, 0, 0, 0);
    send_cmd(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_cmd(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        load_phase(ph);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long result stall in the middle of the first phase
        if (ph == 0 && i == PHASE_ITEMS / 2) hold_req = 1'b1;
        send_random();
      end
    end

    cmd.valid <= 1'b0;
    wait (pending == 0);
    repeat (qmm_pkg::TOTAL_LAT + 10) @(posedge clk_i);
    $display("Sent %0d command requests over 7 register settings, checked %0d results.",
             sent, results);
    $display("Covered saturating gains, degenerate and inverted ranges, stalls and gaps.");
    if (errors == 0)
      $display("PASS quad_motor_mixer_to_pwm_core");
    else
      $display("FAIL quad_motor_mixer_to_pwm_core");
    $finish;
  end

endmodule
